// File: rtl/core/integer_to_ascii_radix_top_assert.svh
// Assertion macros used by the radix converter RTL.
`ifndef INTEGER_TO_ASCII_RADIX_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITOAR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITOAR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/itoar_pkg.sv
// Package with constants and the digit-to-character map of the radix converter.
`default_nettype none

package itoar_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 7;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // Register index of the radix register (byte address bit 2).
    localparam logic REG_RADIX = 1'b0;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;
    localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

    // Digits 0..9 map to '0'..'9', digits 10..35 to 'a'..'z'.
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/integer_to_ascii_radix_top.sv
// Integer to ASCII converter with a programmable radix, bit-serial divider.
// Usage:
//   A value enters on the s_ stream; its characters leave on the m_ stream,
//   most significant first, with m_tlast on the final one. The radix is set
//   through the APB port (register 0, reset 10, bits 5:0). A radix outside
//   2..36 gives a single request with m_tuser high and a zero character.
//   Write the radix only while the block is idle.
// Timing:
//   Each digit comes from restoring division, one dividend bit per cycle
//   through a shift register. After the last division step the block
//   enters the emit state, which loads the first character into the output
//   register once that register is free; the rest follow one per cycle
//   while the receiver takes them. The number of digits is set by the radix
//   and the size of the value. A bad radix result skips division and goes
//   from acceptance through the emit state into the output register.
//   s_tready rises again once the last character sits in the output
//   register, so the next value starts while that character waits.
// Reset and stall:
//   aresetn (synchronous, active low) empties the block and sets the radix
//   to 10. When m_tready is low and a character waits, the output register
//   holds and no digit leaves the stack, so nothing is lost.
`default_nettype none

module integer_to_ascii_radix_top #(
    parameter int VALUE_WIDTH = itoar_pkg::VALUE_WIDTH_DEF,
    localparam int IN_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input stream. s_tdata: value [VALUE_WIDTH-1:0], zero pad above.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [IN_W-1:0]                  s_tdata,
    // Result stream. m_tdata: digit_char [6:0], zero pad [7].
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [7:0]                            m_tdata,
    output logic                                  m_tlast,
    // m_tuser: bad_base [0].
    output logic                                  m_tuser,
    // Configuration port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [itoar_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [itoar_pkg::APB_DATA_W-1:0] pwdata,
    output logic [itoar_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);
    import itoar_pkg::*;

    localparam int BIT_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(VALUE_WIDTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [RADIX_W-1:0]     rem_reg, rem_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   bad_reg, bad_next;
    logic [RADIX_W-1:0]     stack_reg [VALUE_WIDTH];
    logic [RADIX_W-1:0]     stack_next [VALUE_WIDTH];
    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]      m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;
    logic                   m_bad_reg, m_bad_next;

    logic                   cfg_wr;
    logic                   in_take;
    logic                   out_free;
    logic                   radix_bad;
    logic [RADIX_W:0]       trial;
    logic                   q_bit;
    logic [RADIX_W-1:0]     rem_step;
    logic [VALUE_WIDTH-1:0] val_step;
    logic                   push;
    logic                   pop;

    // Configuration port: one register, always ready.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = APB_DATA_W'(radix_reg);

    always_comb begin
        radix_next = radix_reg;
        if (cfg_wr && (paddr[2] == REG_RADIX)) begin
            radix_next = pwdata[RADIX_W-1:0];
        end
    end

    // Handshake helpers.
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_take   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign radix_bad = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);

    // One restoring division step: bring in the next dividend bit.
    assign trial    = {rem_reg, val_reg[VALUE_WIDTH-1]};
    assign q_bit    = (trial >= {1'b0, radix_reg});
    assign rem_step = q_bit ? RADIX_W'(trial - {1'b0, radix_reg}) : trial[RADIX_W-1:0];
    assign val_step = {val_reg[VALUE_WIDTH-2:0], q_bit};

    assign push = (state_reg == ST_DIV) && (bit_reg == LAST_BIT);
    assign pop  = (state_reg == ST_EMIT) && out_free;

    // Sequencer: load, divide digit by digit, then emit from the stack; a bad radix skips division and emits one zero.
    always_comb begin
        state_next = state_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    val_next = s_tdata[VALUE_WIDTH-1:0];
                    rem_next = '0;
                    bit_next = '0;
                    bad_next = radix_bad;
                    if (radix_bad) begin
                        cnt_next   = CNT_W'(1);
                        state_next = ST_EMIT;
                    end else begin
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                val_next = val_step;
                if (push) begin
                    rem_next = '0;
                    bit_next = '0;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (val_step == '0) begin
                        state_next = ST_EMIT;
                    end
                end else begin
                    rem_next = rem_step;
                    bit_next = bit_reg + BIT_W'(1);
                end
            end
            ST_EMIT: begin
                if (pop) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Digit stack as a shift register: push at the top, pop from the top.
    always_comb begin
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            stack_next[i] = stack_reg[i];
        end
        if (push) begin
            stack_next[0] = rem_step;
            for (int i = 1; i < VALUE_WIDTH; i++) begin
                stack_next[i] = stack_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
                stack_next[i] = stack_reg[i+1];
            end
        end
    end

    // Output register: loaded on pop, cleared when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_bad_next   = m_bad_reg;
        if (pop) begin
            m_valid_next = 1'b1;
            m_char_next  = bad_reg ? '0 : digit_ascii(stack_reg[0]);
            m_last_next  = (cnt_reg == CNT_W'(1));
            m_bad_next   = bad_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            radix_reg   <= RADIX_RESET;
            cnt_reg     <= '0;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            radix_reg   <= radix_next;
            cnt_reg     <= cnt_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        rem_reg    <= rem_next;
        bad_reg    <= bad_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_bad_reg  <= m_bad_next;
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            stack_reg[i] <= stack_next[i];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_bad_reg;

    // Checks on the sequencer and the result framing.
`include "integer_to_ascii_radix_top_assert.svh"
    `ITOAR_ASSERT_NOW(a_bad_frame, aclk, aresetn,
        m_tvalid && m_tuser, m_tlast && (m_tdata == 8'd0),
        "bad radix result must be a single zero character")
    `ITOAR_ASSERT_NOW(a_stack_room, aclk, aresetn,
        state_reg == ST_DIV, cnt_reg < CNT_W'(VALUE_WIDTH),
        "digit stack overflow during division")
    `ITOAR_ASSERT_NOW(a_emit_count, aclk, aresetn,
        state_reg == ST_EMIT, cnt_reg != '0,
        "emit state entered with an empty stack")
    `ITOAR_ASSERT_NEXT(a_accept_busy, aclk, aresetn,
        in_take, !s_tready,
        "block stays ready right after accepting a value")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the integer to ASCII radix converter.

module testbench;

    import itoar_pkg::*;

    localparam int  HALF_PERIOD   = 10;
    localparam int  RESET_CYCLES  = 8;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  DRAIN_CYCLES  = 300;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  RAND_PHASES   = 7;
    localparam int  PHASE_VALUES  = 13;

    // APB byte addresses: the radix register and a word past the register list.
    localparam logic [APB_ADDR_W-1:0] RADIX_ADDR = 3'd0;
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;

    // One expected character request on the result stream.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } char_rec_t;

    // Predicts the character sequence of each accepted value and checks results.
    class digit_scoreboard;
        char_rec_t         pending_chars[$];
        logic [RADIX_W-1:0] base;
        int                errors;
        int                values_seen;
        int                chars_seen;

        function new();
            base        = RADIX_RESET;
            errors      = 0;
            values_seen = 0;
            chars_seen  = 0;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        // Works out the characters of one value, most significant first.
        function void note_value(logic [VALUE_WIDTH_DEF-1:0] v);
            logic [CHAR_W-1:0]          digs[VALUE_WIDTH_DEF];
            logic [VALUE_WIDTH_DEF-1:0] rest;
            int unsigned                rem;
            int                         n;
            char_rec_t                  rec;
            values_seen++;
            if (base < RADIX_MIN || base > RADIX_MAX) begin
                rec.ch   = '0;
                rec.last = 1'b1;
                rec.bad  = 1'b1;
                pending_chars.push_back(rec);
                return;
            end
            rest = v;
            n = 0;
            do begin
                rem  = rest % base;
                rest = rest / base;
                if (rem < 10) begin
                    digs[n] = 7'h30 + CHAR_W'(rem);
                end else begin
                    digs[n] = 7'h61 + CHAR_W'(rem - 10);
                end
                n++;
            end while (rest != 0);
            for (int k = n - 1; k >= 0; k--) begin
                rec.ch   = digs[k];
                rec.last = (k == 0);
                rec.bad  = 1'b0;
                pending_chars.push_back(rec);
            end
        endfunction

        // Compares one accepted character with the oldest expectation.
        function void check_char(logic [7:0] data, logic last, logic bad);
            char_rec_t exp_rec;
            chars_seen++;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected result data=%h last=%b bad_base=%b",
                         $time, data, last, bad);
                errors++;
                return;
            end
            exp_rec = pending_chars.pop_front();
            if (data[CHAR_W-1:0] !== exp_rec.ch) begin
                $display("%0t: digit_char expected %h actual %h",
                         $time, exp_rec.ch, data[CHAR_W-1:0]);
                errors++;
            end
            if (data[7] !== 1'b0) begin
                $display("%0t: tdata pad expected 0 actual %b", $time, data[7]);
                errors++;
            end
            if (last !== exp_rec.last) begin
                $display("%0t: is_last expected %b actual %b", $time, exp_rec.last, last);
                errors++;
            end
            if (bad !== exp_rec.bad) begin
                $display("%0t: bad_base expected %b actual %b", $time, exp_rec.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    digit_scoreboard sb;
    bit              quiet;
    bit              hold_long;
    int              cycles;
    int              radix_writes;

    integer_to_ascii_radix_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock.
    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d characters outstanding", $time, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Every accepted character request is checked against the prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_char(m_tdata, m_tlast, m_tuser);
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_long = 1'b0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // Offers one value, with an optional idle burst in front of it.
    task automatic send_value(input logic [15:0] v);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        sb.note_value(v);
    endtask

    // Waits until every predicted character has come and the block is idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sets a new radix once idle, with junk in the unused upper bits, and reads it back.
    task automatic set_radix(input logic [RADIX_W-1:0] base);
        logic [APB_DATA_W-1:0] rd;
        wait_idle();
        apb_write(RADIX_ADDR, {26'($urandom_range(0, 32'h03FF_FFFF)), base});
        sb.base = base;
        radix_writes++;
        apb_read(RADIX_ADDR, rd);
        if (rd[RADIX_W-1:0] !== sb.base) begin
            $display("%0t: radix readback expected %h actual %h",
                     $time, sb.base, rd[RADIX_W-1:0]);
            sb.errors++;
        end
    endtask

    // Picks a random value: full range, a few digits, or a random bit length.
    function automatic logic [15:0] pick_value(logic [RADIX_W-1:0] base);
        logic [15:0] v;
        case ($urandom_range(0, 2))
            0: v = 16'($urandom_range(0, 65535));
            1: v = 16'($urandom_range(0, int'(base) * int'(base)));
            default: v = 16'($urandom) & 16'((32'd1 << $urandom_range(1, 16)) - 1);
        endcase
        return v;
    endfunction

    // Mostly a valid radix, sometimes one that must be flagged.
    function automatic logic [RADIX_W-1:0] pick_radix();
        logic [RADIX_W-1:0] r;
        if ($urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
                r = RADIX_W'($urandom_range(0, 1));
            end else begin
                r = RADIX_W'($urandom_range(37, 63));
            end
        end else begin
            r = RADIX_W'($urandom_range(2, 36));
        end
        return r;
    endfunction

    // Main sequence: directed extremes, then random phases with changing radix.
    initial begin
        logic [RADIX_W-1:0] base;
        sb           = new();
        quiet        = 1'b0;
        hold_long    = 1'b0;
        cycles       = 0;
        radix_writes = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset radix of ten: zero, extremes and a digit rollover.
        send_value(16'd0);
        send_value(16'hFFFF);
        send_value(16'd1);
        send_value(16'd9);
        send_value(16'd10);
        send_value(16'd12345);

        // Smallest radix gives the longest runs.
        set_radix(6'd2);
        send_value(16'hFFFF);
        send_value(16'd0);
        send_value(16'h8000);
        send_value(16'd1);

        // Largest radix reaches the last letter.
        set_radix(6'd36);
        send_value(16'd35);
        send_value(16'd36);
        send_value(16'hFFFF);
        send_value(16'd0);
        send_value(16'd1295);

        set_radix(6'd16);
        send_value(16'hA5F0);

        // A write past the register list must leave the radix alone.
        wait_idle();
        apb_write(SPARE_ADDR, 32'($urandom));
        send_value(16'hBEEF);

        // Invalid radix values at both ends of the register range.
        set_radix(6'd0);
        send_value(16'd1234);
        set_radix(6'd1);
        send_value(16'd0);
        set_radix(6'd37);
        send_value(16'hFFFF);
        set_radix(6'd63);
        send_value(16'd7);

        // Random phases; the second one holds the receiver off for a long stretch.
        for (int p = 0; p < RAND_PHASES; p++) begin
            base = pick_radix();
            set_radix(base);
            quiet = (p == RAND_PHASES - 1);
            if (p == 1) begin
                hold_long = 1'b1;
            end
            for (int i = 0; i < PHASE_VALUES; i++) begin
                send_value(pick_value(base));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Converted %0d values into %0d characters over %0d radix settings.",
                 sb.values_seen, sb.chars_seen, radix_writes + 1);
        $display("Covered radix extremes, invalid bases, zero and full-scale values, stalls.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d characters never arrived", sb.errors, sb.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
